// File: rtl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OBB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define OBB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/obb_pkg.sv
// Types, codes and constant tables of the oriented box overlap tester.
package obb_pkg;

	localparam int CORNER_COUNT = 8;
	localparam int STEP_COUNT   = 9;

	// configuration register indexes
	localparam logic [1:0] REG_A_CENTER   = 2'd0;
	localparam logic [1:0] REG_A_SIZE     = 2'd1;
	localparam logic [1:0] REG_A_ROTATION = 2'd2;

	localparam logic [63:0] ROT_RESET = 64'h4000_0000_0000_0000;

	// Q4.28 one
	localparam logic signed [35:0] RAW_ONE = 36'sd268435456;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_QUAT,
		PH_AXES,
		PH_TERM,
		PH_CENT,
		PH_PROJ,
		PH_DRAIN,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic signed [15:0] b_center_x;
		logic signed [15:0] b_center_y;
		logic signed [15:0] b_center_z;
		logic [15:0]        b_size_x;
		logic [15:0]        b_size_y;
		logic [15:0]        b_size_z;
		logic signed [15:0] b_quat_w;
		logic signed [15:0] b_quat_x;
		logic signed [15:0] b_quat_y;
		logic signed [15:0] b_quat_z;
	} box_req_t;

	typedef struct packed {
		logic overlap;
	} box_rsp_t;

	// tag that follows a product into the writeback stage
	typedef struct packed {
		logic       vld;
		phase_t     ph;
		logic       box;
		logic [3:0] idx;
		logic [1:0] j;
		logic [2:0] k;
		logic [1:0] i;
		logic       dir;
	} wb_tag_t;

	// quaternion products: xx yy zz xy xz yz wx wy wz (lane 0 = w)
	localparam logic [1:0] QP_A [STEP_COUNT] = '{2'd1, 2'd2, 2'd3, 2'd1, 2'd1, 2'd2,
		2'd0, 2'd0, 2'd0};
	localparam logic [1:0] QP_B [STEP_COUNT] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3,
		2'd1, 2'd2, 2'd3};

	// flat index n = 3*i + j over axis i, lane j
	localparam logic [1:0] AX_I [STEP_COUNT] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1,
		2'd2, 2'd2, 2'd2};
	localparam logic [1:0] AX_J [STEP_COUNT] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2,
		2'd0, 2'd1, 2'd2};

	// round Q4.28 to Q2.14 and saturate to 16 bits
	function automatic logic signed [15:0] axis_lane(logic signed [35:0] raw);
		logic signed [35:0] sh;
		sh = (raw + 36'sd8192) >>> 14;
		if (sh > 36'sd32767)
			return 16'sh7fff;
		else if (sh < -36'sd32768)
			return 16'sh8000;
		else
			return sh[15:0];
	endfunction

endpackage

// File: rtl/obb_stream_if.sv
// Valid/ready channel carrying one payload struct.
interface obb_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/oriented_box_overlap_test_core.sv
// Oriented box overlap tester: face-axis separating test of box B against box A.
//
//   channel    dir  payload                               handshake
//   ---------  ---  ------------------------------------  -----------------
//   cfg        in   cfg_index 2b, cfg_wdata 64b           cfg_we, no wait
//   box_in     in   box_req_t: B center, size, quat       valid/ready
//   result     out  box_rsp_t: overlap                    valid/ready
//
// After a request is accepted, the block computes 9 quaternion
// products, builds the axes, then 9 extent terms, 9 center terms and 144
// corner-lane projections, all through the one shared multiplier, with a
// writeback step after each 9-product phase, then a drain step and the
// output load, which raises result.valid. box_in.ready rises in the same
// cycle, so a new request is taken only once the last one is through.
// A config write rebuilds box A. After reset the block builds A from
// the reset registers before box_in.ready rises. A finished result sits
// in the output register while the next request is accepted; a stalled
// result holds the sequencer only if a second result is ready behind it.
module oriented_box_overlap_test_core #(
	parameter int COORD_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_wdata,
	obb_stream_if.sink   box_in,
	obb_stream_if.source result
);
	import obb_pkg::*;

	localparam int CB  = COORD_BITS + 8;           // corner lane width
	localparam int MA  = (CB > 17) ? CB : 17;      // multiplier A width
	localparam int PW  = MA + 17;                  // product width
	localparam int AW  = PW + 2;                   // projection sum width
	localparam int CW  = AW + 2;                   // interval compare width
	localparam int SW  = (CB + 2 > 37) ? CB + 2 : 37; // corner sum width
	localparam int TW  = 33;                       // axis * extent
	localparam int PCW = 36;                       // center projection

	localparam logic signed [SW-1:0] CHI = {{(SW-CB+1){1'b0}}, {(CB-1){1'b1}}};
	localparam logic signed [SW-1:0] CLO = ~CHI;

	// ---------------- configuration registers ----------------
	logic [47:0] a_center_q;
	logic [47:0] a_size_q;
	logic [63:0] a_rot_q;
	logic        cfg_hit;

	assign cfg_hit = cfg_we && (cfg_index == REG_A_CENTER || cfg_index == REG_A_SIZE ||
		cfg_index == REG_A_ROTATION);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_center_q <= '0;
			a_size_q   <= '0;
			a_rot_q    <= ROT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_A_CENTER:   a_center_q <= cfg_wdata[47:0];
				REG_A_SIZE:     a_size_q   <= cfg_wdata[47:0];
				REG_A_ROTATION: a_rot_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// ---------------- sequencer state ----------------
	phase_t     ph_q, ph_d;
	logic       box_q;        // 0: box A, 1: box B
	logic [3:0] cnt_q;
	logic [1:0] j_q, i_q;
	logic [2:0] k_q;
	logic       dir_q;        // 0: B corners on A axes, 1: A corners on B axes
	logic       proj_last;
	logic       in_acc;
	logic       issue;
	logic       out_load;

	box_req_t   breq_q;

	// ---------------- per-box derived state ----------------
	logic signed [31:0]    qp_q   [STEP_COUNT];
	logic signed [15:0]    axis_q [2][STEP_COUNT];
	logic signed [TW-1:0]  t_q    [2][STEP_COUNT];
	logic signed [PCW-1:0] p_q    [2][3];

	logic signed [PW-1:0]  prod_s1;
	wb_tag_t               tag_s1;
	logic signed [AW-1:0]  acc_q, mn_q, mx_q;
	logic                  sep_q;
	logic                  ov_q, ovl_q;

	// box geometry views
	logic signed [15:0] cen  [2][3];
	logic [15:0]        siz  [2][3];
	logic signed [15:0] quat [4];

	assign cen[0][0] = a_center_q[47:32];
	assign cen[0][1] = a_center_q[31:16];
	assign cen[0][2] = a_center_q[15:0];
	assign cen[1][0] = breq_q.b_center_x;
	assign cen[1][1] = breq_q.b_center_y;
	assign cen[1][2] = breq_q.b_center_z;
	assign siz[0][0] = a_size_q[47:32];
	assign siz[0][1] = a_size_q[31:16];
	assign siz[0][2] = a_size_q[15:0];
	assign siz[1][0] = breq_q.b_size_x;
	assign siz[1][1] = breq_q.b_size_y;
	assign siz[1][2] = breq_q.b_size_z;

	assign quat[0] = box_q ? breq_q.b_quat_w : a_rot_q[63:48];
	assign quat[1] = box_q ? breq_q.b_quat_x : a_rot_q[47:32];
	assign quat[2] = box_q ? breq_q.b_quat_y : a_rot_q[31:16];
	assign quat[3] = box_q ? breq_q.b_quat_z : a_rot_q[15:0];

	assign in_acc    = box_in.valid && box_in.ready;
	assign proj_last = dir_q && (i_q == 2'd2) && (k_q == 3'd7) && (j_q == 2'd2);

	// ---------------- next phase ----------------
	always_comb begin
		ph_d = ph_q;
		case (ph_q)
			PH_IDLE:  if (in_acc) ph_d = PH_QUAT;
			PH_QUAT:  if (cnt_q == 4'd9) ph_d = PH_AXES;
			PH_AXES:  ph_d = PH_TERM;
			PH_TERM:  if (cnt_q == 4'd9) ph_d = PH_CENT;
			PH_CENT:  if (cnt_q == 4'd9) ph_d = box_q ? PH_PROJ : PH_IDLE;
			PH_PROJ:  if (proj_last) ph_d = PH_DRAIN;
			PH_DRAIN: ph_d = PH_DONE;
			PH_DONE:  if (!ov_q || result.ready) ph_d = PH_IDLE;
			default:  ph_d = PH_IDLE;
		endcase
		// a register write rebuilds box A
		if (cfg_hit)
			ph_d = PH_QUAT;
	end

	// ---------------- phase outputs ----------------
	always_comb begin
		issue    = 1'b0;
		out_load = 1'b0;
		case (ph_q)
			PH_QUAT, PH_TERM, PH_CENT: issue = (cnt_q != 4'd9);
			PH_PROJ: issue = 1'b1;
			PH_DONE: out_load = !ov_q || result.ready;
			default: ;
		endcase
	end

	assign box_in.ready = (ph_q == PH_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= PH_QUAT;
			box_q <= 1'b0;
			cnt_q <= '0;
			j_q   <= '0;
			k_q   <= '0;
			i_q   <= '0;
			dir_q <= 1'b0;
		end else begin
			ph_q <= ph_d;
			if (cfg_hit)
				box_q <= 1'b0;
			else if (in_acc)
				box_q <= 1'b1;
			cnt_q <= (ph_d != ph_q || cfg_hit) ? 4'd0 : cnt_q + 4'd1;
			if (ph_q != PH_PROJ) begin
				j_q   <= '0;
				k_q   <= '0;
				i_q   <= '0;
				dir_q <= 1'b0;
			end else if (j_q == 2'd2) begin
				j_q <= '0;
				if (k_q == 3'd7) begin
					k_q <= '0;
					if (i_q == 2'd2) begin
						i_q   <= '0;
						dir_q <= 1'b1;
					end else begin
						i_q <= i_q + 2'd1;
					end
				end else begin
					k_q <= k_q + 3'd1;
				end
			end else begin
				j_q <= j_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc)
			breq_q <= box_in.data;
	end

	// ---------------- corner lane of the point box ----------------
	logic               pb;      // box whose corners are projected
	logic               rb;      // box whose axes and interval are used
	logic [3:0]         sidx;    // step index, held in range at the end of each phase
	logic [3:0]         ax_n;
	logic signed [SW-1:0] crn_v, crn_sh;
	logic signed [CB-1:0] corner;

	assign pb   = ~dir_q;
	assign rb   = dir_q;
	assign sidx = (cnt_q == 4'd9) ? 4'd0 : cnt_q;
	assign ax_n = 4'({2'b00, i_q}) * 4'd3 + 4'({2'b00, j_q});

	always_comb begin
		crn_v = SW'(cen[pb][j_q]) <<< 15;
		crn_v = k_q[2] ? crn_v + SW'(t_q[pb][4'({2'b00, j_q})])
			: crn_v - SW'(t_q[pb][4'({2'b00, j_q})]);
		crn_v = k_q[1] ? crn_v + SW'(t_q[pb][4'({2'b00, j_q}) + 4'd3])
			: crn_v - SW'(t_q[pb][4'({2'b00, j_q}) + 4'd3]);
		crn_v = k_q[0] ? crn_v + SW'(t_q[pb][4'({2'b00, j_q}) + 4'd6])
			: crn_v - SW'(t_q[pb][4'({2'b00, j_q}) + 4'd6]);
		crn_sh = (crn_v + SW'(8192)) >>> 14;
		if (crn_sh > CHI)
			corner = CHI[CB-1:0];
		else if (crn_sh < CLO)
			corner = CLO[CB-1:0];
		else
			corner = crn_sh[CB-1:0];
	end

	// ---------------- shared multiplier ----------------
	logic signed [MA-1:0] mul_a;
	logic signed [16:0]   mul_b;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (ph_q)
			PH_QUAT: begin
				mul_a = MA'(quat[QP_A[sidx]]);
				mul_b = 17'(quat[QP_B[sidx]]);
			end
			PH_TERM: begin
				mul_a = MA'(axis_q[box_q][sidx]);
				mul_b = signed'({1'b0, siz[box_q][AX_I[sidx]]});
			end
			PH_CENT: begin
				mul_a = MA'(cen[box_q][AX_J[sidx]]);
				mul_b = 17'(axis_q[box_q][sidx]);
			end
			PH_PROJ: begin
				mul_a = MA'(corner);
				mul_b = 17'(axis_q[rb][ax_n]);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1.vld <= issue && !cfg_hit;
			tag_s1.ph  <= ph_q;
			tag_s1.box <= box_q;
			tag_s1.idx <= sidx;
			tag_s1.j   <= j_q;
			tag_s1.k   <= k_q;
			tag_s1.i   <= i_q;
			tag_s1.dir <= dir_q;
		end
	end

	// ---------------- axis build (Q4.28 rotation matrix) ----------------
	logic signed [35:0] e [STEP_COUNT];
	logic signed [15:0] lane [STEP_COUNT];

	always_comb begin
		for (int n = 0; n < STEP_COUNT; n++)
			e[n] = 36'(qp_q[n]);
		// e: 0 xx, 1 yy, 2 zz, 3 xy, 4 xz, 5 yz, 6 wx, 7 wy, 8 wz
		lane[0] = axis_lane(RAW_ONE - ((e[1] + e[2]) <<< 1));
		lane[1] = axis_lane((e[3] + e[8]) <<< 1);
		lane[2] = axis_lane((e[4] - e[7]) <<< 1);
		lane[3] = axis_lane((e[3] - e[8]) <<< 1);
		lane[4] = axis_lane(RAW_ONE - ((e[0] + e[2]) <<< 1));
		lane[5] = axis_lane((e[5] + e[6]) <<< 1);
		lane[6] = axis_lane((e[4] + e[7]) <<< 1);
		lane[7] = axis_lane((e[5] - e[6]) <<< 1);
		lane[8] = axis_lane(RAW_ONE - ((e[0] + e[1]) <<< 1));
	end

	// ---------------- projection writeback ----------------
	logic signed [AW-1:0] full, nmn, nmx;
	logic signed [CW-1:0] ivl_lo, ivl_hi, ext;
	logic                 rbw;

	assign rbw = tag_s1.dir;

	always_comb begin
		full = ((tag_s1.j == 2'd0) ? AW'(0) : acc_q) + AW'(prod_s1);
		nmn  = (tag_s1.k == 3'd0 || full < mn_q) ? full : mn_q;
		nmx  = (tag_s1.k == 3'd0 || full > mx_q) ? full : mx_q;
		ext  = signed'({{(CW-30){1'b0}}, siz[rbw][tag_s1.i], 14'd0});
		ivl_lo = CW'(p_q[rbw][tag_s1.i]) - ext;
		ivl_hi = CW'(p_q[rbw][tag_s1.i]) + ext;
	end

	always_ff @(posedge clk) begin
		if (ph_q == PH_AXES) begin
			for (int n = 0; n < STEP_COUNT; n++)
				axis_q[box_q][n] <= lane[n];
			for (int n = 0; n < 3; n++)
				p_q[box_q][n] <= '0;
		end
		if (tag_s1.vld) begin
			case (tag_s1.ph)
				PH_QUAT: qp_q[tag_s1.idx] <= signed'(prod_s1[31:0]);
				PH_TERM: t_q[tag_s1.box][tag_s1.idx] <= signed'(prod_s1[TW-1:0]);
				PH_CENT: p_q[tag_s1.box][AX_I[tag_s1.idx]] <=
					p_q[tag_s1.box][AX_I[tag_s1.idx]] +
					(PCW'(signed'(prod_s1[31:0])) <<< 1);
				PH_PROJ: begin
					acc_q <= full;
					if (tag_s1.j == 2'd2) begin
						mn_q <= nmn;
						mx_q <= nmx;
					end
				end
				default: ;
			endcase
		end
	end

	// separation flag: any interval strictly apart clears the overlap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_q <= 1'b0;
		end else if (in_acc) begin
			sep_q <= 1'b0;
		end else if (tag_s1.vld && tag_s1.ph == PH_PROJ && tag_s1.j == 2'd2 &&
			tag_s1.k == 3'd7) begin
			if (CW'(nmx) < ivl_lo || CW'(nmn) > ivl_hi)
				sep_q <= 1'b1;
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (out_load) begin
			ov_q <= 1'b1;
		end else if (result.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load)
			ovl_q <= ~sep_q;
	end

	assign result.valid        = ov_q;
	assign result.data.overlap = ovl_q;

endmodule

// File: rtl/obb_checker.sv
// Port-level checker for the overlap tester, bound to its top level.
`include "assert_macros.svh"

module obb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       out_overlap,
	input logic       cfg_we,
	input logic [1:0] cfg_index
);
	import obb_pkg::*;

	// ready drops once a request is accepted
	`OBB_ASSERT_NEXT(a_busy_after_req, clk, arst_n, in_valid && in_ready, !in_ready,
		"ready stayed high after a request")
	// a register write rebuilds box A, so no request is taken next
	`OBB_ASSERT_NEXT(a_busy_after_cfg, clk, arst_n,
		cfg_we && (cfg_index == REG_A_CENTER || cfg_index == REG_A_SIZE ||
		cfg_index == REG_A_ROTATION), !in_ready, "request taken during rebuild")
	`OBB_ASSERT_NEXT(a_result_held, clk, arst_n, out_valid && !out_ready, out_valid,
		"stalled result dropped")
	`OBB_ASSERT_NEXT(a_result_stable, clk, arst_n, out_valid && !out_ready,
		$stable(out_overlap), "stalled result changed")

endmodule

bind oriented_box_overlap_test_core obb_checker u_obb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (box_in.valid),
	.in_ready   (box_in.ready),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.out_overlap(result.data.overlap),
	.cfg_we     (cfg_we),
	.cfg_index  (cfg_index)
);

// File: dv/tb_top.sv
// Self-checking testbench of the oriented box overlap tester.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import obb_pkg::*;

	// Geometry of one box as the block derives it: axes Q2.14,
	// corners Q.9, projection intervals Q.23.
	typedef struct {
		longint ax [3][3];
		longint cr [8][3];
		longint iv [3][2];
	} box_geom_t;

	localparam int CORNER_W    = 16 + 8;
	localparam int DRAIN_WAIT  = 400;  // above one request's full run through the block
	localparam int HOLD_CYCLES = 3000; // long result stall to back up the block

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_wdata;

	obb_stream_if #(.payload_t(box_req_t)) box_in_if ();
	obb_stream_if #(.payload_t(box_rsp_t)) result_if ();

	oriented_box_overlap_test_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.box_in    (box_in_if.sink),
		.result    (result_if.source)
	);

	// Shadow copy of the box A registers and their derived geometry.
	logic [47:0] a_center_q;
	logic [47:0] a_size_q;
	logic [63:0] a_rot_q;
	box_geom_t   a_geom;

	box_req_t pending_reqs [$];   // requests waiting to be offered
	logic     overlap_due  [$];   // predicted overlap flags, oldest first

	int send_idle_pct;
	int recv_idle_pct;
	int n_sent;
	int n_checked;
	int n_hits;
	int n_mismatch;
	bit failed;

	// long receiver stall, requested by the stimulus, timed here
	bit hold_go;
	bit hold_done;
	int hold_cnt;

	function automatic longint sat_to(longint v, int bits);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		lo = -hi - 1;
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	// round Q.28 to Q.14 (add half, floor), saturated to 16 bits
	function automatic longint round_axis(longint raw);
		return sat_to((raw + 8192) >>> 14, 16);
	endfunction

	// Derive axes, corners and intervals from packed center/size/quaternion.
	function automatic box_geom_t derive_geom(logic [47:0] center, logic [47:0] size,
			logic [63:0] quat);
		box_geom_t g;
		longint c [3];
		longint s [3];
		longint q [4];
		longint raw [3][3];
		longint one;
		longint v;
		longint p;
		one = longint'(1) <<< 28;
		for (int j = 0; j < 3; j++) begin
			c[j] = longint'($signed(center[47 - 16 * j -: 16]));
			s[j] = longint'(size[47 - 16 * j -: 16]);
		end
		for (int j = 0; j < 4; j++)
			q[j] = longint'($signed(quat[63 - 16 * j -: 16]));
		// rotation matrix of q, row i is axis i
		raw[0][0] = one - 2 * (q[2] * q[2] + q[3] * q[3]);
		raw[0][1] = 2 * (q[1] * q[2] + q[0] * q[3]);
		raw[0][2] = 2 * (q[1] * q[3] - q[0] * q[2]);
		raw[1][0] = 2 * (q[1] * q[2] - q[0] * q[3]);
		raw[1][1] = one - 2 * (q[1] * q[1] + q[3] * q[3]);
		raw[1][2] = 2 * (q[2] * q[3] + q[0] * q[1]);
		raw[2][0] = 2 * (q[1] * q[3] + q[0] * q[2]);
		raw[2][1] = 2 * (q[2] * q[3] - q[0] * q[1]);
		raw[2][2] = one - 2 * (q[1] * q[1] + q[2] * q[2]);
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				g.ax[i][j] = round_axis(raw[i][j]);
		// corner k: bit 2 picks +x axis, bit 1 +y, bit 0 +z
		for (int k = 0; k < 8; k++)
			for (int j = 0; j < 3; j++) begin
				v = c[j] * 2 * 16384;
				for (int i = 0; i < 3; i++)
					if ((k >> (2 - i)) & 1)
						v += g.ax[i][j] * s[i];
					else
						v -= g.ax[i][j] * s[i];
				g.cr[k][j] = sat_to((v + 8192) >>> 14, CORNER_W);
			end
		for (int i = 0; i < 3; i++) begin
			p = 0;
			for (int j = 0; j < 3; j++)
				p += c[j] * 2 * g.ax[i][j];
			g.iv[i][0] = p - s[i] * 16384;
			g.iv[i][1] = p + s[i] * 16384;
		end
		return g;
	endfunction

	// corners of pts projected on axis i of ref fall strictly outside ref's interval
	function automatic bit gap_on_axis(box_geom_t pts, box_geom_t ref_box, int i);
		longint mn;
		longint mx;
		longint p;
		mn = 0;
		mx = 0;
		for (int k = 0; k < 8; k++) begin
			p = 0;
			for (int j = 0; j < 3; j++)
				p += pts.cr[k][j] * ref_box.ax[i][j];
			if (k == 0 || p < mn)
				mn = p;
			if (k == 0 || p > mx)
				mx = p;
		end
		return mx < ref_box.iv[i][0] || mn > ref_box.iv[i][1];
	endfunction

	function automatic logic predict_overlap(box_req_t r);
		box_geom_t b;
		b = derive_geom({r.b_center_x, r.b_center_y, r.b_center_z},
			{r.b_size_x, r.b_size_y, r.b_size_z},
			{r.b_quat_w, r.b_quat_x, r.b_quat_y, r.b_quat_z});
		for (int i = 0; i < 3; i++)
			if (gap_on_axis(b, a_geom, i) || gap_on_axis(a_geom, b, i))
				return 1'b0;
		return 1'b1;
	endfunction

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// run limit: far above the slowest legal run
	initial begin
		#20_000_000;
		$display("tb: failure");
		$finish;
	end

	// Driver: offers queued requests; each accepted one is predicted
	// against the box A state current at acceptance.
	always @(posedge clk) begin
		if (box_in_if.valid && box_in_if.ready) begin
			overlap_due.push_back(predict_overlap(box_in_if.data));
			void'(pending_reqs.pop_front());
			n_sent++;
		end
		if (!box_in_if.valid || box_in_if.ready) begin
			if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				box_in_if.valid <= 1'b1;
				box_in_if.data  <= pending_reqs[0];
			end else begin
				box_in_if.valid <= 1'b0;
			end
		end
	end

	// long stall of the result side, counted here
	always @(posedge clk) begin
		if (hold_go && !hold_done) begin
			if (hold_cnt == HOLD_CYCLES)
				hold_done <= 1'b1;
			hold_cnt <= hold_cnt + 1;
		end
	end

	// Monitor: compare each result with the oldest prediction.
	always @(posedge clk) begin
		if (result_if.valid && result_if.ready) begin
			if (overlap_due.size() == 0) begin
				failed = 1'b1;
				n_mismatch++;
				if (n_mismatch <= 10)
					$display("unexpected result overlap=%0b", result_if.data.overlap);
			end else begin
				if (result_if.data.overlap !== overlap_due[0]) begin
					failed = 1'b1;
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("mismatch on result %0d: overlap expected %0b got %0b",
							n_checked, overlap_due[0], result_if.data.overlap);
				end
				if (overlap_due[0])
					n_hits++;
				void'(overlap_due.pop_front());
				n_checked++;
			end
		end
		result_if.ready <= !(hold_go && !hold_done) && $urandom_range(99) >= recv_idle_pct;
	end

	// one register write; the shadow state is updated when the write is driven
	task automatic write_reg(logic [1:0] idx, logic [63:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		case (idx)
			REG_A_CENTER:   a_center_q = value[47:0];
			REG_A_SIZE:     a_size_q   = value[47:0];
			REG_A_ROTATION: a_rot_q    = value;
			default: ;
		endcase
		a_geom = derive_geom(a_center_q, a_size_q, a_rot_q);
	endtask

	task automatic set_box_a(logic [47:0] center, logic [47:0] size, logic [63:0] rot);
		write_reg(REG_A_CENTER, {16'h0000, center});
		write_reg(REG_A_SIZE, {16'h0000, size});
		write_reg(REG_A_ROTATION, rot);
		// index 3 is unmapped: the block must ignore it
		write_reg(2'd3, {$urandom, $urandom});
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait until every request is answered, then let the block settle
	task automatic wait_idle();
		while (pending_reqs.size() > 0 || overlap_due.size() > 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	function automatic box_req_t make_req(logic [47:0] c, logic [47:0] s, logic [63:0] q);
		box_req_t r;
		{r.b_center_x, r.b_center_y, r.b_center_z} = c;
		{r.b_size_x, r.b_size_y, r.b_size_z} = s;
		{r.b_quat_w, r.b_quat_x, r.b_quat_y, r.b_quat_z} = q;
		return r;
	endfunction

	// unit quaternions, including quarter turns and an exact half turn
	logic [63:0] unit_rots [8] = '{
		64'h4000_0000_0000_0000,  // identity
		64'h2d41_0000_0000_2d41,  // 90 deg about z
		64'h2d41_2d41_0000_0000,  // 90 deg about x
		64'h2d41_0000_d2bf_0000,  // -90 deg about y
		64'h0000_4000_0000_0000,  // 180 deg about x
		64'h2000_2000_2000_2000,  // 120 deg about the diagonal
		64'hc000_0000_0000_0000,  // -identity
		64'h3b21_0000_187e_0000   // 45 deg about y
	};

	function automatic logic [63:0] pick_rot();
		logic [63:0] q;
		if ($urandom_range(9) < 8)
			return unit_rots[$urandom_range(7)];
		// non-unit lanes across the full field range
		q = {$urandom, $urandom};
		return q;
	endfunction

	// Random box B: mostly near box A with moderate sizes, so both
	// outcomes are common; some fully random lanes for bit coverage.
	function automatic box_req_t rand_req();
		logic [47:0] c;
		logic [47:0] s;
		logic [15:0] lane;
		if ($urandom_range(9) < 7) begin
			for (int j = 0; j < 3; j++) begin
				lane = a_center_q[47 - 16 * j -: 16] + 16'($signed($urandom_range(2048)) - 1024);
				c[47 - 16 * j -: 16] = lane;
				s[47 - 16 * j -: 16] = 16'($urandom_range(16'h0600));
			end
		end else begin
			c = 48'({$urandom, $urandom});
			s = 48'({$urandom, $urandom});
		end
		return make_req(c, s, pick_rot());
	endfunction

	task automatic queue_random(int count);
		repeat (count) begin
			@(posedge clk);
			pending_reqs.push_back(rand_req());
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = '0;
		cfg_wdata       = '0;
		box_in_if.valid = 1'b0;
		box_in_if.data  = '0;
		result_if.ready = 1'b0;
		send_idle_pct   = 9;
		recv_idle_pct   = 56;
		hold_go         = 1'b0;
		hold_done       = 1'b0;
		hold_cnt        = 0;
		failed          = 1'b0;
		a_center_q      = '0;
		a_size_q        = '0;
		a_rot_q         = ROT_RESET;
		a_geom          = derive_geom(a_center_q, a_size_q, a_rot_q);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Reset box A is a point at the origin: B boxes around it.
		pending_reqs.push_back(make_req('0, '0, 64'h4000_0000_0000_0000));
		pending_reqs.push_back(make_req({16'h0100, 32'h0}, {3{16'h0100}}, unit_rots[1]));
		pending_reqs.push_back(make_req({16'h0080, 32'h0}, {3{16'h0100}}, unit_rots[0]));
		pending_reqs.push_back(make_req({3{16'h7fff}}, {3{16'hffff}}, unit_rots[0]));
		pending_reqs.push_back(make_req({3{16'h8000}}, {3{16'hffff}}, unit_rots[5]));
		wait_idle();

		// A 2x2x2 at origin: touching faces, slight gap, zero-size B,
		// flat B, non-unit and saturating quaternions.
		set_box_a('0, {3{16'h0200}}, ROT_RESET);
		pending_reqs.push_back(make_req({16'h0200, 32'h0}, {3{16'h0200}}, unit_rots[0]));
		pending_reqs.push_back(make_req({16'h0201, 32'h0}, {3{16'h0200}}, unit_rots[0]));
		pending_reqs.push_back(make_req({16'h0, 16'hfe00, 16'h0}, {3{16'h0200}}, unit_rots[6]));
		pending_reqs.push_back(make_req({3{16'h0080}}, '0, unit_rots[0]));
		pending_reqs.push_back(make_req({3{16'h0300}}, '0, unit_rots[0]));
		pending_reqs.push_back(make_req('0, {16'h0400, 16'h0400, 16'h0}, unit_rots[2]));
		pending_reqs.push_back(make_req('0, {3{16'h0100}}, {4{16'h7fff}}));
		pending_reqs.push_back(make_req('0, {3{16'h0100}}, {4{16'h8000}}));
		pending_reqs.push_back(make_req({16'h0280, 32'h0}, {3{16'h0100}}, {4{16'h4000}}));
		pending_reqs.push_back(make_req({16'h0200, 16'h0200, 16'h0}, {3{16'h0200}},
			unit_rots[1]));
		pending_reqs.push_back(make_req({16'h0300, 32'h0}, {3{16'h0200}}, unit_rots[1]));
		pending_reqs.push_back(make_req({3{16'h8000}}, {3{16'hffff}}, {4{16'hc000}}));
		wait_idle();

		// A at the field extremes
		set_box_a({3{16'h7fff}}, {3{16'hffff}}, {4{16'h7fff}});
		pending_reqs.push_back(make_req({3{16'h7fff}}, {3{16'hffff}}, unit_rots[0]));
		pending_reqs.push_back(make_req({3{16'h8000}}, '0, unit_rots[3]));
		queue_random(60);
		wait_idle();

		set_box_a({3{16'h8000}}, '0, {4{16'h8000}});
		pending_reqs.push_back(make_req({3{16'h8000}}, '0, unit_rots[0]));
		queue_random(60);
		wait_idle();

		// receiver idles little, sender much
		send_idle_pct = 56;
		recv_idle_pct = 9;
		set_box_a({16'h0100, 16'hff00, 16'h0040}, {16'h0300, 16'h0100, 16'h0200}, unit_rots[1]);
		queue_random(100);
		wait_idle();

		set_box_a(48'({$urandom, $urandom}), 48'({$urandom, $urandom}), unit_rots[5]);
		queue_random(100);
		wait_idle();

		// no idling; then a long result stall while requests keep coming
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_box_a({16'hfe00, 16'h0080, 16'h0000}, {3{16'h0400}}, unit_rots[7]);
		hold_go = 1'b1;
		queue_random(120);
		wait_idle();

		set_box_a(48'({$urandom, $urandom}), {16'h0500, 16'h0040, 16'h0280},
			{$urandom, $urandom});
		queue_random(80);
		wait_idle();

		set_box_a('0, {3{16'h0300}}, unit_rots[4]);
		queue_random(100);
		wait_idle();

		if (overlap_due.size() > 0)
			failed = 1'b1;
		$display("tb: %0d boxes sent, %0d checked (%0d overlapping) over 9 box A settings",
			n_sent, n_checked, n_hits);
		$display("tb: idle mixes, a %0d-cycle result stall, %0d mismatches",
			HOLD_CYCLES, n_mismatch);
		if (!failed && n_mismatch == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
